/* hw/rtl/tra_pkg.sv */
// ============================================================================
// tra_pkg: shared types and constants of the two-level rejecting averager
// Field widths, the controller state type and the divider status word.
// ============================================================================
package tra_pkg;

  localparam int unsigned RAW_W = 16;  // raw reading width
  localparam int unsigned SUM_W = 23;  // block sum width, also divider dividend width
  localparam int unsigned CNT_W = 8;   // block count width, also divider divisor width
  localparam int unsigned AVG_W = 15;  // block average and result width

  // Readings at or above this value are rejected as outliers.
  localparam logic [RAW_W-1:0] REJECT_LIMIT = 16'h8000;

  // Reset value of the readings-per-average register.
  localparam logic [CNT_W-1:0] RPA_RESET = 8'd10;

  // One quotient bit is produced per divider step.
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK_DIV,
    ST_STAGE2,
    ST_OUT_DIV,
    ST_EMIT
  } tra_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tra_div_status_t;

endpackage

/* hw/rtl/tra_if.sv */
// ============================================================================
// tra_if: word channels of the two-level rejecting averager
// Valid/ready channels for raw readings and for filtered results.
// ============================================================================
interface tra_in_if;
  logic                      valid;
  logic                      ready;
  logic [tra_pkg::RAW_W-1:0] raw_reading;

  modport source (output valid, output raw_reading, input ready);
  modport sink (input valid, input raw_reading, output ready);
endinterface

interface tra_out_if;
  logic                      valid;
  logic                      ready;
  logic [tra_pkg::AVG_W-1:0] filtered_value;
  logic                      no_valid_data;

  modport source (output valid, output filtered_value, output no_valid_data, input ready);
  modport sink (input valid, input filtered_value, input no_valid_data, output ready);
endinterface

/* hw/rtl/tra_divider.sv */
// ============================================================================
// tra_divider: bit-serial restoring divider
// Produces one quotient bit per cycle; the dividend shifts out of the top of
// the quotient register while quotient bits shift in at the bottom.
// ============================================================================
module tra_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tra_pkg::SUM_W-1:0] dividend_i,
  input  logic [tra_pkg::CNT_W-1:0] divisor_i,
  output logic [tra_pkg::SUM_W-1:0] quotient_o,
  output tra_pkg::tra_div_status_t  status_o
);
  import tra_pkg::*;

  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     den_q, den_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

/* hw/rtl/two_level_rejecting_averager_unit.sv */
// ============================================================================
// two_level_rejecting_averager_unit: cascaded block average with rejection
// Averages raw proximity readings in blocks, dropping outliers, then
// averages the nonzero block averages into one filtered result word.
// ============================================================================
//
//   Channel     Direction  Contents
//   reading_i   in         raw_reading[15:0]
//   result_o    out        filtered_value[14:0], no_valid_data
//   cfg_we_i/   in         readings_per_average[7:0], write only
//   cfg_data_i
//
// A reading that does not close a block leaves the input ready, so such
// readings may arrive back to back. A reading that closes a block holds off
// the input while the bit-serial divider forms the block average, one
// quotient bit per cycle over 23 bits, if any reading in it was accepted. A
// reading that also closes a result holds off the input longer, as the same
// divider runs a second time for the result. Reset clears all counts and sums
// and loads readings_per_average with 10. A result word waits in the output
// register while the input keeps flowing; only the next result stalls on it.
//
module two_level_rejecting_averager_unit #(
  parameter int unsigned AVERAGES_PER_RESULT = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tra_in_if.sink                    reading_i,
  tra_out_if.source                 result_o,
  input  logic                      cfg_we_i,
  input  logic [tra_pkg::CNT_W-1:0] cfg_data_i
);
  import tra_pkg::*;

  // Stage two widths follow from the number of averages per result.
  localparam int unsigned AIW = $clog2(AVERAGES_PER_RESULT + 1);
  localparam int unsigned OSW = AVG_W + AIW;

  // Controller state.
  tra_state_e state_q, state_d;

  // Configuration register.
  logic [CNT_W-1:0] rpa_q;

  // Stage one: running block sum, accepted count and readings taken.
  logic [SUM_W-1:0] blk_sum_q, blk_sum_d;
  logic [CNT_W-1:0] blk_cnt_q, blk_cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;

  // Stage two: sum and count of nonzero averages, and averages taken.
  logic [OSW-1:0]   out_sum_q, out_sum_d;
  logic [AIW-1:0]   out_cnt_q, out_cnt_d;
  logic [AIW-1:0]   avg_idx_q, avg_idx_d;

  // Latest block average and the pending result.
  logic [AVG_W-1:0] avg_q, avg_d;
  logic [AVG_W-1:0] res_val_q, res_val_d;
  logic             res_flag_q, res_flag_d;

  // Output register.
  logic             ovalid_q, ovalid_d;
  logic [AVG_W-1:0] oval_q, oval_d;
  logic             oflag_q, oflag_d;

  // Shared divider.
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic [SUM_W-1:0] div_quotient;
  tra_div_status_t  div_st;

  // Terms used by both the next-state and the output logic.
  logic             in_accept;
  logic [CNT_W-1:0] limit;
  logic             raw_ok;
  logic [SUM_W-1:0] blk_sum_add;
  logic [CNT_W-1:0] blk_cnt_add;
  logic [CNT_W-1:0] rd_idx_inc;
  logic             blk_end;
  logic             avg_nz;
  logic [OSW-1:0]   out_sum_add;
  logic [AIW-1:0]   out_cnt_add;
  logic [AIW-1:0]   avg_idx_inc;
  logic             res_end;
  logic             out_free;

  tra_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .status_o   (div_st)
  );

  assign reading_i.ready = (state_q == ST_IDLE);
  assign in_accept       = reading_i.valid && reading_i.ready;

  // A length of zero behaves as a length of one.
  assign limit = (rpa_q == '0) ? CNT_W'(1) : rpa_q;

  // Outliers are dropped from both the sum and the count.
  assign raw_ok      = reading_i.raw_reading < REJECT_LIMIT;
  assign blk_sum_add = blk_sum_q + (raw_ok ? SUM_W'(reading_i.raw_reading) : '0);
  assign blk_cnt_add = blk_cnt_q + CNT_W'(raw_ok);
  assign rd_idx_inc  = rd_idx_q + 1'b1;
  // Greater-or-equal so that a length lowered mid-block ends it at once.
  assign blk_end     = rd_idx_inc >= limit;

  // Only nonzero block averages enter the stage two sum and count.
  assign avg_nz      = avg_q != '0;
  assign out_sum_add = out_sum_q + OSW'(avg_q);
  assign out_cnt_add = out_cnt_q + AIW'(avg_nz);
  assign avg_idx_inc = avg_idx_q + 1'b1;
  assign res_end     = avg_idx_inc >= AIW'(AVERAGES_PER_RESULT);

  // The output register can take a new word when empty or being drained.
  assign out_free = !ovalid_q || result_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && blk_end) begin
          state_d = (blk_cnt_add != '0) ? ST_BLK_DIV : ST_STAGE2;
        end
      end
      ST_BLK_DIV: begin
        if (div_st.done) begin
          state_d = ST_STAGE2;
        end
      end
      ST_STAGE2: begin
        if (res_end) begin
          state_d = (out_cnt_add != '0) ? ST_OUT_DIV : ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT_DIV: begin
        if (div_st.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and divider control.
  always_comb begin
    blk_sum_d    = blk_sum_q;
    blk_cnt_d    = blk_cnt_q;
    rd_idx_d     = rd_idx_q;
    out_sum_d    = out_sum_q;
    out_cnt_d    = out_cnt_q;
    avg_idx_d    = avg_idx_q;
    avg_d        = avg_q;
    res_val_d    = res_val_q;
    res_flag_d   = res_flag_q;
    oval_d       = oval_q;
    oflag_d      = oflag_q;
    ovalid_d     = ovalid_q && !result_o.ready;
    div_start    = 1'b0;
    div_dividend = blk_sum_add;
    div_divisor  = blk_cnt_add;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (blk_end) begin
            blk_sum_d = '0;
            blk_cnt_d = '0;
            rd_idx_d  = '0;
            if (blk_cnt_add != '0) begin
              div_start = 1'b1;
            end else begin
              // A block with no accepted reading averages to zero.
              avg_d = '0;
            end
          end else begin
            blk_sum_d = blk_sum_add;
            blk_cnt_d = blk_cnt_add;
            rd_idx_d  = rd_idx_inc;
          end
        end
      end
      ST_BLK_DIV: begin
        if (div_st.done) begin
          avg_d = div_quotient[AVG_W-1:0];
        end
      end
      ST_STAGE2: begin
        if (res_end) begin
          out_sum_d = '0;
          out_cnt_d = '0;
          avg_idx_d = '0;
          if (out_cnt_add != '0) begin
            div_start    = 1'b1;
            div_dividend = SUM_W'(out_sum_add);
            div_divisor  = CNT_W'(out_cnt_add);
          end else begin
            // Every block average was zero: report an empty result.
            res_val_d  = '0;
            res_flag_d = 1'b1;
          end
        end else begin
          out_sum_d = avg_nz ? out_sum_add : out_sum_q;
          out_cnt_d = out_cnt_add;
          avg_idx_d = avg_idx_inc;
        end
      end
      ST_OUT_DIV: begin
        if (div_st.done) begin
          res_val_d  = div_quotient[AVG_W-1:0];
          res_flag_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          oval_d   = res_val_q;
          oflag_d  = res_flag_q;
          ovalid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rpa_q     <= RPA_RESET;
      blk_sum_q <= '0;
      blk_cnt_q <= '0;
      rd_idx_q  <= '0;
      out_sum_q <= '0;
      out_cnt_q <= '0;
      avg_idx_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        rpa_q <= cfg_data_i;
      end
      blk_sum_q <= blk_sum_d;
      blk_cnt_q <= blk_cnt_d;
      rd_idx_q  <= rd_idx_d;
      out_sum_q <= out_sum_d;
      out_cnt_q <= out_cnt_d;
      avg_idx_q <= avg_idx_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q      <= avg_d;
    res_val_q  <= res_val_d;
    res_flag_q <= res_flag_d;
    oval_q     <= oval_d;
    oflag_q    <= oflag_d;
  end

  assign result_o.valid          = ovalid_q;
  assign result_o.filtered_value = oval_q;
  assign result_o.no_valid_data  = oflag_q;

  // The divider is only started when it is free.
  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // While waiting on a quotient, the divider is working or just finished.
  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLK_DIV || state_q == ST_OUT_DIV) |-> (div_st.busy || div_st.done))
    else $error("waiting on a divider that is not running");

  // An empty result always carries a zero value.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oflag_q) |-> (oval_q == '0))
    else $error("empty result with nonzero value");

  // The averages taken never reach the number per result between results.
  a_avg_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_idx_q < AIW'(AVERAGES_PER_RESULT))
    else $error("average index out of range");

endmodule
